// ----- rtl/core/fspp_pkg.sv -----
// ----------------------------------------------------------------------------
// fspp_pkg: shared types, codes and tables of the flagged section parser
// Transaction structs, parse phase codes, section tables and helpers.
// ----------------------------------------------------------------------------
package fspp_pkg;

    localparam int MAX_EFFECTS_DEF = 32;
    localparam int MAX_STRING_DEF  = 31;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [15:0] payload_length;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  field_code;
        logic [7:0]  element_index;
        logic [31:0] field_value;
        logic [1:0]  status;
        logic        end_of_payload;
    } t_out_item;

    // up to two results per accepted byte, field result in slot 0
    typedef struct packed {
        logic      push0;
        logic      push1;
        t_out_item item0;
        t_out_item item1;
    } t_push;

    // parse phases, equal to the field code being assembled
    localparam logic [4:0] PH_HEADER      = 5'd0;
    localparam logic [4:0] PH_EXHAUSTION  = 5'd3;
    localparam logic [4:0] PH_BOOTS       = 5'd8;
    localparam logic [4:0] PH_EFF_COUNT   = 5'd9;
    localparam logic [4:0] PH_EFF_ID      = 5'd10;
    localparam logic [4:0] PH_EFF_AMP     = 5'd11;
    localparam logic [4:0] PH_EFF_DUR     = 5'd12;
    localparam logic [4:0] PH_PING        = 5'd13;
    localparam logic [4:0] PH_FIRE        = 5'd16;
    localparam logic [4:0] PH_EXPERIENCE  = 5'd19;
    localparam logic [4:0] PH_STATE_FLAGS = 5'd20;
    localparam logic [4:0] PH_RAINING     = 5'd22;
    localparam logic [4:0] PH_GAMEMODE    = 5'd23;
    localparam logic [4:0] PH_BIOME_LEN   = 5'd24;
    localparam logic [4:0] PH_BIOME_CHR   = 5'd25;
    localparam logic [4:0] PH_DIM_LEN     = 5'd26;
    localparam logic [4:0] PH_DIM_CHR     = 5'd27;
    localparam logic [4:0] PH_DONE        = 5'd28;

    localparam logic [4:0] FC_STATUS = 5'd0;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd2;
    localparam logic [1:0] ST_BAD_VER   = 2'd3;

    localparam logic REG_MAGIC   = 1'b0;
    localparam logic REG_VERSION = 1'b1;

    localparam int HEADER_LEN = 8;
    localparam int EFFECT_LEN = 5;

    // section search order: from this section on
    localparam logic [3:0] SEC_FOOD    = 4'd0;
    localparam logic [3:0] SEC_ARMOR   = 4'd1;
    localparam logic [3:0] SEC_EFFECTS = 4'd2;
    localparam logic [3:0] SEC_PING    = 4'd3;
    localparam logic [3:0] SEC_AIR     = 4'd4;
    localparam logic [3:0] SEC_XP      = 4'd5;
    localparam logic [3:0] SEC_STATE   = 4'd6;
    localparam logic [3:0] SEC_DAY     = 4'd7;
    localparam logic [3:0] SEC_BIOME   = 4'd8;
    localparam logic [3:0] SEC_DIM     = 4'd9;
    localparam logic [3:0] SEC_NONE    = 4'd10;

    localparam int NSECT = 10;
    localparam logic [7:0] SECT_MASK [NSECT] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h40, 8'h40, 8'h40};
    localparam logic [3:0] SECT_NEED [NSECT] = '{
        4'd9, 4'd5, 4'd1, 4'd4, 4'd6, 4'd8, 4'd1, 4'd4, 4'd1, 4'd1};
    localparam logic [4:0] SECT_FIRST [NSECT] = '{
        5'd1, 5'd4, 5'd9, 5'd13, 5'd14, 5'd17, 5'd20, 5'd21, 5'd24, 5'd26};

    function automatic logic [2:0] field_width(input logic [4:0] ph);
        logic [2:0] w;
        case (ph)
            5'd2, 5'd3, 5'd13, 5'd18:             w = 3'd4;
            5'd10, 5'd12, 5'd14, 5'd15, 5'd16,
            5'd17, 5'd19, 5'd21:                  w = 3'd2;
            default:                              w = 3'd1;
        endcase
        return w;
    endfunction

    // first flagged section from k on that fits at the offset
    function automatic logic [4:0] pick_section(input logic [3:0]  k,
                                                input logic [7:0]  flags,
                                                input logic [16:0] off,
                                                input logic [15:0] len);
        logic [4:0] ph;
        logic       found;
        ph    = PH_DONE;
        found = 1'b0;
        for (int i = 0; i < NSECT; i++) begin
            if (!found && 4'(i) >= k && (flags & SECT_MASK[i]) != 8'd0 &&
                off + 17'(SECT_NEED[i]) <= {1'b0, len}) begin
                ph    = SECT_FIRST[i];
                found = 1'b1;
            end
        end
        return ph;
    endfunction

endpackage

// ----- rtl/core/fspp_result_fifo.sv -----
// ----------------------------------------------------------------------------
// fspp_result_fifo: four-entry result queue
// Takes up to two results a cycle, hands out one result transaction a cycle while the consumer is ready.
// ----------------------------------------------------------------------------
module fspp_result_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fspp_pkg::t_push     i_push,
    output logic                o_has_room,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fspp_pkg::t_out_item o_out_item
);

    fspp_pkg::t_out_item r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_count;
    logic [1:0] n_wr;
    logic [1:0] n_rd;
    logic [2:0] n_count;
    logic       pop;

    assign o_has_room  = r_count <= 3'd2;
    assign o_out_valid = r_count != 3'd0;
    assign o_out_item  = r_mem[r_rd];
    assign pop         = o_out_valid && i_out_ready;

    always_comb begin
        n_wr    = r_wr + {1'b0, i_push.push0} + {1'b0, i_push.push1};
        n_rd    = r_rd + {1'b0, pop};
        n_count = r_count + {2'b0, i_push.push0} + {2'b0, i_push.push1} - {2'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr] <= i_push.item0;
        end
        if (i_push.push1) begin
            r_mem[r_wr + 2'd1] <= i_push.item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ----- rtl/core/flagged_section_payload_parser_core.sv -----
// ----------------------------------------------------------------------------
// flagged_section_payload_parser_core: byte-serial flagged section parser
// Checks header magic and version, decodes flagged sections, emits tagged
// field results and one status result at the end of every non-empty payload.
// ----------------------------------------------------------------------------
// Throughput: one byte transaction per cycle while the result queue has room;
//   a byte that closes a field and the payload yields two results, drained one
//   per cycle while the consumer is ready from a four-entry result queue.
// Results: each result is registered in the queue before it is offered.
// Reset: synchronous, active low; clears parse state, queue and registers.
// ----------------------------------------------------------------------------
module flagged_section_payload_parser_core #(
    parameter int MAX_EFFECTS = fspp_pkg::MAX_EFFECTS_DEF,
    parameter int MAX_STRING  = fspp_pkg::MAX_STRING_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fspp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fspp_pkg::t_out_item o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // configuration registers
    logic [31:0] r_magic;
    logic [7:0]  r_version;

    // parse state
    logic [15:0] r_offset,    n_offset;
    logic [4:0]  r_phase,     n_phase;
    logic [7:0]  r_flags,     n_flags;
    logic [31:0] r_asm,       n_asm;
    logic [2:0]  r_cnt,       n_cnt;
    logic [7:0]  r_eff_left,  n_eff_left;
    logic [7:0]  r_eff_num,   n_eff_num;
    logic [4:0]  r_str_left,  n_str_left;
    logic [4:0]  r_str_pos,   n_str_pos;
    logic [1:0]  r_reject,    n_reject;

    fspp_pkg::t_push push;
    logic        has_room;
    logic        in_fire;

    assign pready     = 1'b1;
    assign o_in_ready = has_room;
    assign in_fire    = i_in_valid && o_in_ready;

    // register read-back
    always_comb begin
        case (paddr[2])
            fspp_pkg::REG_MAGIC:   prdata = r_magic;
            fspp_pkg::REG_VERSION: prdata = {24'd0, r_version};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= '0;
            r_version <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                fspp_pkg::REG_MAGIC:   r_magic   <= pwdata;
                fspp_pkg::REG_VERSION: r_version <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // one parse step per accepted byte
    always_comb begin
        logic [7:0]  b;
        logic [15:0] len;
        logic [15:0] pos;
        logic [16:0] nxt;
        logic [31:0] asm_v;
        logic [31:0] val;
        logic [31:0] cap;
        logic [2:0]  cnt_v;
        logic        emit;
        logic [4:0]  e_code;
        logic [7:0]  e_idx;
        logic [31:0] e_val;

        n_offset   = r_offset;
        n_phase    = r_phase;
        n_flags    = r_flags;
        n_asm      = r_asm;
        n_cnt      = r_cnt;
        n_eff_left = r_eff_left;
        n_eff_num  = r_eff_num;
        n_str_left = r_str_left;
        n_str_pos  = r_str_pos;
        n_reject   = r_reject;
        push       = '0;

        b      = i_in_item.data_byte;
        len    = i_in_item.payload_length;
        pos    = '0;
        nxt    = '0;
        asm_v  = '0;
        val    = '0;
        cap    = '0;
        cnt_v  = '0;
        emit   = 1'b0;
        e_code = '0;
        e_idx  = '0;
        e_val  = '0;

        if (in_fire) begin
            // restart mark: begin from a clean header state
            if (i_in_item.first_byte) begin
                n_offset   = '0;
                n_phase    = fspp_pkg::PH_HEADER;
                n_flags    = '0;
                n_asm      = '0;
                n_cnt      = '0;
                n_eff_left = '0;
                n_eff_num  = '0;
                n_str_left = '0;
                n_str_pos  = '0;
                n_reject   = '0;
            end

            // bytes past the end are dropped and do not advance the offset
            if (n_offset < len) begin
                pos      = n_offset;
                nxt      = {1'b0, pos} + 17'd1;
                n_offset = nxt[15:0];

                if (n_phase == fspp_pkg::PH_HEADER) begin
                    if (pos < 16'd4) begin
                        n_asm = n_asm | (32'(b) << {pos[1:0], 3'b000});
                    end
                    if (pos == 16'd3 && n_asm != r_magic) begin
                        n_reject = fspp_pkg::ST_BAD_MAGIC;
                        n_phase  = fspp_pkg::PH_DONE;
                    end else if (pos == 16'd4 && b != r_version) begin
                        n_reject = fspp_pkg::ST_BAD_VER;
                        n_phase  = fspp_pkg::PH_DONE;
                    end else if (pos == 16'd5) begin
                        n_flags = b;
                    end else if (pos == 16'(fspp_pkg::HEADER_LEN - 1)) begin
                        n_asm   = '0;
                        n_phase = fspp_pkg::pick_section(fspp_pkg::SEC_FOOD, n_flags, nxt, len);
                    end
                end else if (n_phase != fspp_pkg::PH_DONE) begin
                    // collect little-endian field bytes
                    asm_v = n_asm | (32'(b) << {n_cnt[1:0], 3'b000});
                    cnt_v = n_cnt + 3'd1;
                    if (cnt_v < fspp_pkg::field_width(n_phase)) begin
                        n_asm = asm_v;
                        n_cnt = cnt_v;
                    end else begin
                        n_asm  = '0;
                        n_cnt  = '0;
                        val    = asm_v;
                        emit   = 1'b1;
                        e_code = n_phase;
                        e_val  = val;
                        case (n_phase)
                            fspp_pkg::PH_EFF_COUNT: begin
                                cap        = (val < 32'(MAX_EFFECTS)) ? val : 32'(MAX_EFFECTS);
                                e_val      = cap;
                                n_eff_left = cap[7:0];
                                n_eff_num  = '0;
                                if (cap[7:0] != 8'd0 &&
                                    nxt + 17'(fspp_pkg::EFFECT_LEN) <= {1'b0, len}) begin
                                    n_phase = fspp_pkg::PH_EFF_ID;
                                end else begin
                                    n_phase = fspp_pkg::pick_section(fspp_pkg::SEC_PING,
                                                                     n_flags, nxt, len);
                                end
                            end
                            fspp_pkg::PH_EFF_ID, fspp_pkg::PH_EFF_AMP: begin
                                e_idx   = n_eff_num;
                                n_phase = n_phase + 5'd1;
                            end
                            fspp_pkg::PH_EFF_DUR: begin
                                e_idx     = n_eff_num;
                                n_eff_num = n_eff_num + 8'd1;
                                if (n_eff_left != 8'd0) begin
                                    n_eff_left = n_eff_left - 8'd1;
                                end
                                if (n_eff_left != 8'd0 &&
                                    nxt + 17'(fspp_pkg::EFFECT_LEN) <= {1'b0, len}) begin
                                    n_phase = fspp_pkg::PH_EFF_ID;
                                end else begin
                                    n_phase = fspp_pkg::pick_section(fspp_pkg::SEC_PING,
                                                                     n_flags, nxt, len);
                                end
                            end
                            fspp_pkg::PH_RAINING: begin
                                e_val   = {31'd0, val != 32'd0};
                                n_phase = fspp_pkg::PH_GAMEMODE;
                            end
                            fspp_pkg::PH_BIOME_LEN, fspp_pkg::PH_DIM_LEN: begin
                                cap = (val < 32'(MAX_STRING)) ? val : 32'(MAX_STRING);
                                // string that does not fit: consume the length byte only
                                if (nxt + 17'(cap[4:0]) <= {1'b0, len}) begin
                                    e_val      = cap;
                                    n_str_left = cap[4:0];
                                    n_str_pos  = '0;
                                end else begin
                                    emit = 1'b0;
                                end
                                if (emit && cap[4:0] != 5'd0) begin
                                    n_phase = n_phase + 5'd1;
                                end else begin
                                    n_phase = fspp_pkg::pick_section(
                                        (n_phase == fspp_pkg::PH_BIOME_LEN) ?
                                            fspp_pkg::SEC_DIM : fspp_pkg::SEC_NONE,
                                        n_flags, nxt, len);
                                end
                            end
                            fspp_pkg::PH_BIOME_CHR, fspp_pkg::PH_DIM_CHR: begin
                                e_idx     = {3'd0, n_str_pos};
                                n_str_pos = n_str_pos + 5'd1;
                                if (n_str_left != 5'd0) begin
                                    n_str_left = n_str_left - 5'd1;
                                end
                                if (n_str_left == 5'd0) begin
                                    n_phase = fspp_pkg::pick_section(
                                        (n_phase == fspp_pkg::PH_BIOME_CHR) ?
                                            fspp_pkg::SEC_DIM : fspp_pkg::SEC_NONE,
                                        n_flags, nxt, len);
                                end
                            end
                            fspp_pkg::PH_EXHAUSTION:
                                n_phase = fspp_pkg::pick_section(fspp_pkg::SEC_ARMOR,
                                                                 n_flags, nxt, len);
                            fspp_pkg::PH_BOOTS:
                                n_phase = fspp_pkg::pick_section(fspp_pkg::SEC_EFFECTS,
                                                                 n_flags, nxt, len);
                            fspp_pkg::PH_PING:
                                n_phase = fspp_pkg::pick_section(fspp_pkg::SEC_AIR,
                                                                 n_flags, nxt, len);
                            fspp_pkg::PH_FIRE:
                                n_phase = fspp_pkg::pick_section(fspp_pkg::SEC_XP,
                                                                 n_flags, nxt, len);
                            fspp_pkg::PH_EXPERIENCE:
                                n_phase = fspp_pkg::pick_section(fspp_pkg::SEC_STATE,
                                                                 n_flags, nxt, len);
                            fspp_pkg::PH_STATE_FLAGS:
                                n_phase = fspp_pkg::pick_section(fspp_pkg::SEC_DAY,
                                                                 n_flags, nxt, len);
                            fspp_pkg::PH_GAMEMODE:
                                n_phase = fspp_pkg::pick_section(fspp_pkg::SEC_BIOME,
                                                                 n_flags, nxt, len);
                            default:
                                n_phase = n_phase + 5'd1;
                        endcase
                    end
                end

                // field result first, status result behind it
                push.item0.field_code     = e_code;
                push.item0.element_index  = e_idx;
                push.item0.field_value    = e_val;
                push.item0.status         = fspp_pkg::ST_OK;
                push.item0.end_of_payload = 1'b0;
                push.push0                = emit;

                if (nxt == {1'b0, len}) begin
                    push.item1.field_code     = fspp_pkg::FC_STATUS;
                    push.item1.element_index  = '0;
                    push.item1.field_value    = '0;
                    push.item1.status         = (len < 16'(fspp_pkg::HEADER_LEN)) ?
                                                fspp_pkg::ST_SHORT : n_reject;
                    push.item1.end_of_payload = 1'b1;
                    if (emit) begin
                        push.push1 = 1'b1;
                    end else begin
                        push.push0 = 1'b1;
                        push.item0 = push.item1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= '0;
            r_phase    <= fspp_pkg::PH_HEADER;
            r_flags    <= '0;
            r_asm      <= '0;
            r_cnt      <= '0;
            r_eff_left <= '0;
            r_eff_num  <= '0;
            r_str_left <= '0;
            r_str_pos  <= '0;
            r_reject   <= '0;
        end else begin
            r_offset   <= n_offset;
            r_phase    <= n_phase;
            r_flags    <= n_flags;
            r_asm      <= n_asm;
            r_cnt      <= n_cnt;
            r_eff_left <= n_eff_left;
            r_eff_num  <= n_eff_num;
            r_str_left <= n_str_left;
            r_str_pos  <= n_str_pos;
            r_reject   <= n_reject;
        end
    end

    // result queue: hold finished results until the consumer takes them
    fspp_result_fifo u_result_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_has_room  (has_room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
